@@ src/rlac_pkg.sv @@
// Package with the shared types and constants of the remote link arming controller.
package rlac_pkg;

   localparam int unsigned PeriodWidth   = 16;
   localparam int unsigned BitIndexWidth = 3;
   localparam int unsigned StatusWidth   = 8;
   localparam int unsigned ThrottleWidth = 10;
   localparam int unsigned ModeCodeWidth = 2;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [StatusWidth-1:0] ByteMask = 8'hFF;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_SEND_PERIOD        = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FLASH_PERIOD       = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ON_BIT_INDEX       = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_IN_RANGE_BIT_INDEX = 2'd3;

   // Configuration reset values.
   localparam logic [PeriodWidth-1:0]   SendPeriodReset      = 16'd100;
   localparam logic [PeriodWidth-1:0]   FlashPeriodReset     = 16'd1000;
   localparam logic [BitIndexWidth-1:0] OnBitIndexReset      = 3'd0;
   localparam logic [BitIndexWidth-1:0] InRangeBitIndexReset = 3'd1;

   // Mode codes as reported on the result channel.
   localparam logic [ModeCodeWidth-1:0] MODE_CODE_OFF      = 2'd0;
   localparam logic [ModeCodeWidth-1:0] MODE_CODE_IN_RANGE = 2'd1;
   localparam logic [ModeCodeWidth-1:0] MODE_CODE_ON       = 2'd2;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'b001,
      MODE_IN_RANGE = 3'b010,
      MODE_ON       = 3'b100
   } mode_type;

   typedef struct packed {
      logic [PeriodWidth-1:0]   send_period;
      logic [PeriodWidth-1:0]   flash_period;
      logic [BitIndexWidth-1:0] on_bit_index;
      logic [BitIndexWidth-1:0] in_range_bit_index;
   } cfg_type;

   typedef struct packed {
      mode_type                 mode;
      logic                     entering;
      logic [StatusWidth-1:0]   own_status;
      logic [PeriodWidth-1:0]   send_count;
      logic [PeriodWidth-1:0]   flash_count;
      logic                     link_led;
      logic                     alert_led;
   } state_type;

   typedef struct packed {
      logic                     packet_arrived;
      logic [StatusWidth-1:0]   partner_status;
      logic                     button_press;
      logic [ThrottleWidth-1:0] throttle;
   } req_payload_type;

   typedef struct packed {
      logic                     send_now;
      logic [StatusWidth-1:0]   sent_status;
      logic [ThrottleWidth-1:0] sent_speed;
      logic                     link_led;
      logic                     alert_led;
      logic [ModeCodeWidth-1:0] mode_now;
   } rsp_payload_type;

endpackage

@@ src/rlac_req_if.sv @@
// Request channel interface carrying one main-loop tick.
interface rlac_req_if
   import rlac_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     packet_arrived;
   logic [StatusWidth-1:0]   partner_status;
   logic                     button_press;
   logic [ThrottleWidth-1:0] throttle;

   modport source (
      output valid, packet_arrived, partner_status, button_press, throttle,
      input  ready
   );
   modport sink (
      input  valid, packet_arrived, partner_status, button_press, throttle,
      output ready
   );
endinterface

@@ src/rlac_rsp_if.sv @@
// Response channel interface carrying the result of one tick.
interface rlac_rsp_if
   import rlac_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     send_now;
   logic [StatusWidth-1:0]   sent_status;
   logic [ThrottleWidth-1:0] sent_speed;
   logic                     link_led;
   logic                     alert_led;
   logic [ModeCodeWidth-1:0] mode_now;

   modport source (
      output valid, send_now, sent_status, sent_speed, link_led, alert_led, mode_now,
      input  ready
   );
   modport sink (
      input  valid, send_now, sent_status, sent_speed, link_led, alert_led, mode_now,
      output ready
   );
endinterface

@@ src/rlac_tick.sv @@
// Combinational next-state and result logic for one tick of the arming controller.
module rlac_tick
   import rlac_pkg::*;
(
   input  cfg_type         cfg,
   input  state_type       cur,
   input  req_payload_type req,
   output state_type       nxt,
   output rsp_payload_type rsp
);

   logic [StatusWidth-1:0] on_mask;
   logic [StatusWidth-1:0] in_range_mask;
   logic [PeriodWidth-1:0] flash_inc;
   logic [PeriodWidth-1:0] send_base;
   logic                   send;

   assign on_mask       = StatusWidth'(1) << cfg.on_bit_index;
   assign in_range_mask = StatusWidth'(1) << cfg.in_range_bit_index;
   assign flash_inc     = (cur.entering ? '0 : cur.flash_count) + PeriodWidth'(1);

   always_comb begin
      nxt           = cur;
      nxt.entering  = 1'b0;
      send_base     = cur.send_count;
      case (cur.mode)
         MODE_IN_RANGE: begin
            if (cur.entering) begin
               send_base = '0;
            end
            if (flash_inc >= cfg.flash_period) begin
               nxt.link_led    = ~cur.link_led;
               nxt.flash_count = '0;
            end else begin
               nxt.flash_count = flash_inc;
            end
            if (req.button_press) begin
               nxt.own_status = cur.own_status | on_mask;
            end
         end
         MODE_ON: begin
            if (cur.entering) begin
               nxt.own_status = cur.own_status | on_mask;
               nxt.link_led   = 1'b1;
            end
            if (req.button_press) begin
               nxt.own_status = nxt.own_status & (on_mask ^ ByteMask);
            end
         end
         default: begin
            // Off state, also taken for any code that is never reached.
            if (cur.entering) begin
               nxt.flash_count = '0;
               send_base       = '0;
               nxt.own_status  = cur.own_status & (on_mask ^ ByteMask);
               nxt.link_led    = 1'b0;
            end
         end
      endcase

      send           = (send_base >= cfg.send_period);
      nxt.send_count = send ? PeriodWidth'(1) : send_base + PeriodWidth'(1);

      if (req.packet_arrived) begin
         case (cur.mode)
            MODE_IN_RANGE: begin
               if ((req.partner_status & on_mask) != '0) begin
                  nxt.mode     = MODE_ON;
                  nxt.entering = 1'b1;
               end
            end
            MODE_ON: begin
               if ((req.partner_status & on_mask) == '0) begin
                  nxt.alert_led = 1'b1;
                  nxt.mode      = MODE_OFF;
                  nxt.entering  = 1'b1;
               end
            end
            default: begin
               if ((req.partner_status & in_range_mask) != '0) begin
                  nxt.mode     = MODE_IN_RANGE;
                  nxt.entering = 1'b1;
               end
            end
         endcase
      end

      rsp.send_now    = send;
      rsp.sent_status = send ? nxt.own_status : '0;
      rsp.sent_speed  = (send && cur.mode == MODE_ON) ? req.throttle : '0;
      rsp.link_led    = nxt.link_led;
      rsp.alert_led   = nxt.alert_led;
      case (nxt.mode)
         MODE_IN_RANGE: rsp.mode_now = MODE_CODE_IN_RANGE;
         MODE_ON:       rsp.mode_now = MODE_CODE_ON;
         default:       rsp.mode_now = MODE_CODE_OFF;
      endcase
   end

endmodule

@@ src/remote_link_arming_controller.sv @@
// Top level of the remote link arming controller: channel registers, state and configuration.
//
//   Channel   Direction  Handshake         Content
//   req_chan  in         valid / ready     one main-loop tick (packet, button, throttle)
//   rsp_chan  out        valid / ready     send decision, status, speed, LEDs, mode
//   csr_*     in         write enable      send and flash periods, status bit positions
//
// Every accepted request produces exactly one response, passing first through the
// request register and then the response register. A new request is taken every
// cycle while the response side does not stall; the state update is a single pass
// of the tick logic between the two registers. The request register holds while
// the response register is full and not taken, so a stall backs up one deep.
// Reset is synchronous; after it the block accepts requests at once.
module remote_link_arming_controller
   import rlac_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   rlac_req_if.sink                 req_chan,
   rlac_rsp_if.source               rsp_chan,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   cfg_type         cfg_ff;
   state_type       state_ff;
   state_type       state_in;
   logic            req_valid_ff;
   req_payload_type req_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            rsp_free;
   logic            advance;

   // The response register can take a new result when it is empty or being emptied.
   assign rsp_free         = ~rsp_valid_ff | rsp_chan.ready;
   assign advance          = req_valid_ff & rsp_free;
   assign req_chan.ready   = ~req_valid_ff | rsp_free;

   // Configuration registers. The user writes only while the block is idle; no check here.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.send_period        <= SendPeriodReset;
         cfg_ff.flash_period       <= FlashPeriodReset;
         cfg_ff.on_bit_index       <= OnBitIndexReset;
         cfg_ff.in_range_bit_index <= InRangeBitIndexReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SEND_PERIOD:        cfg_ff.send_period  <= csr_write_data;
            CSR_FLASH_PERIOD:       cfg_ff.flash_period <= csr_write_data;
            CSR_ON_BIT_INDEX:       cfg_ff.on_bit_index <= csr_write_data[BitIndexWidth-1:0];
            CSR_IN_RANGE_BIT_INDEX: begin
               cfg_ff.in_range_bit_index <= csr_write_data[BitIndexWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Request register: captures the tick fields at acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_data_ff.packet_arrived <= req_chan.packet_arrived;
         req_data_ff.partner_status <= req_chan.partner_status;
         req_data_ff.button_press   <= req_chan.button_press;
         req_data_ff.throttle       <= req_chan.throttle;
      end
   end

   // One pass of the main-loop tick on the registered request.
   rlac_tick u_tick (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_data_ff),
      .nxt (state_in),
      .rsp (rsp_data_in)
   );

   // Controller state advances exactly when a request moves into the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_OFF;
         state_ff.entering    <= 1'b1;
         state_ff.own_status  <= '0;
         state_ff.send_count  <= '0;
         state_ff.flash_count <= '0;
         state_ff.link_led    <= 1'b0;
         state_ff.alert_led   <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.send_now    = rsp_data_ff.send_now;
   assign rsp_chan.sent_status = rsp_data_ff.sent_status;
   assign rsp_chan.sent_speed  = rsp_data_ff.sent_speed;
   assign rsp_chan.link_led    = rsp_data_ff.link_led;
   assign rsp_chan.alert_led   = rsp_data_ff.alert_led;
   assign rsp_chan.mode_now    = rsp_data_ff.mode_now;

`ifndef SYNTHESIS
   // Once the partner has switched the system off, the alert stays lit.
   a_alert_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.alert_led |=> state_ff.alert_led)
      else $error("alert LED cleared after being set");

   // After the entry actions of the on state the link LED is lit.
   a_on_led_lit: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_ON && !state_ff.entering) |-> state_ff.link_led)
      else $error("link LED dark in on state");

   // After the entry actions of the off state the link LED is dark.
   a_off_led_dark: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_OFF && !state_ff.entering) |-> !state_ff.link_led)
      else $error("link LED lit in off state");

   // A full pipeline behind a stalled response takes no new request.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while pipeline is full");
`endif

endmodule
